// ===== src/table_waveshaper_cubic_defines.svh =====
// ----------------------------------------------------------------------------
// Table waveshaper assertion macros
// Shared assertion shorthand for the waveshaper checker.
// ----------------------------------------------------------------------------
`ifndef TABLE_WAVESHAPER_CUBIC_DEFINES_SVH
`define TABLE_WAVESHAPER_CUBIC_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define TWS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper package
// Constants, the queue item type and the divide-by-five helper.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int unsigned LUT_X_SIZE_DEF = 256;
    localparam int unsigned LUT_D_SIZE_DEF = 32;
    localparam int unsigned TABLE_DEPTH    = 8192;
    localparam int unsigned TABLE_AW       = 13;
    localparam int unsigned COL_MAX_W      = 12;
    localparam int unsigned FRAC_W         = 16;
    localparam int unsigned FIFO_DEPTH     = 4;
    localparam int unsigned FIFO_PW        = $clog2(FIFO_DEPTH);
    localparam int unsigned APB_AW         = 3;

    localparam logic [0:0] MODE_WRITE     = 1'b0;
    localparam logic [0:0] REG_DISTORTION = 1'b0;

    typedef struct packed {
        logic                 is_write;
        logic [TABLE_AW-1:0]  waddr;
        logic [15:0]          wdata;
        logic [COL_MAX_W-1:0] col_m;
        logic [COL_MAX_W-1:0] col_0;
        logic [COL_MAX_W-1:0] col_1;
        logic [COL_MAX_W-1:0] col_2;
        logic [FRAC_W-1:0]    frac;
    } tws_item_t;

    typedef struct packed {
        logic [18:0] quo;
        logic [2:0]  rem;
    } tws_div5_t;

    // Reciprocal multiply undershoots by less than one, so one correction step suffices.
    function automatic tws_div5_t div5(input logic [18:0] m);
        logic [38:0] prod;
        logic [18:0] q;
        logic [18:0] r;
        tws_div5_t   res;
        prod = 39'(m) * 39'd209715;
        q    = prod[38:20];
        r    = m - 19'(q * 19'd5);
        if (r >= 19'd5)
        begin
            q = q + 19'd1;
            r = r - 19'd5;
        end
        res.quo = q;
        res.rem = r[2:0];
        return res;
    endfunction

endpackage

// ===== src/tws_front.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper front end
// Accepts items, clamps the sample and derives column indices and fraction.
// ----------------------------------------------------------------------------
module tws_front import tws_pkg::*; #(
    parameter int unsigned LUT_X_SIZE = LUT_X_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [0:0]         mode,
    input  logic [12:0]        table_address,
    input  logic signed [15:0] table_value,
    input  logic signed [15:0] sample_in,
    input  logic               queue_full,
    output logic               push_valid,
    output tws_item_t          push_item
);

    localparam int unsigned CW = $clog2(LUT_X_SIZE);
    localparam int unsigned PW = 15 + CW;

    logic                 adv;
    logic signed [15:0]   x_cl;
    logic [14:0]          u;
    logic [PW-1:0]        pos;
    tws_div5_t            dq;
    tws_div5_t            df;
    logic [CW-1:0]        c0;
    logic [CW-1:0]        cm;
    logic [CW-1:0]        c1;
    logic [CW-1:0]        c2;
    tws_item_t            item_next;

    logic                 s1_vld_reg;
    logic                 s1_wr_reg;
    logic [TABLE_AW-1:0]  s1_waddr_reg;
    logic [15:0]          s1_wdata_reg;
    logic [PW-1:0]        s1_pos_reg;
    logic                 s2_vld_reg;
    logic                 s2_wr_reg;
    logic [TABLE_AW-1:0]  s2_waddr_reg;
    logic [15:0]          s2_wdata_reg;
    logic [CW-1:0]        s2_c0_reg;
    logic [14:0]          s2_rem_reg;
    logic                 s3_vld_reg;
    tws_item_t            s3_item_reg;

    assign adv        = !(s3_vld_reg && queue_full);
    assign item_ready = adv;
    assign push_valid = s3_vld_reg;
    assign push_item  = s3_item_reg;

    always_comb
    begin
        if (sample_in > 16'sd10240)
            x_cl = 16'sd10240;
        else if (sample_in < -16'sd10240)
            x_cl = -16'sd10240;
        else
            x_cl = sample_in;
        u   = 15'(x_cl + 16'sd10240);
        pos = PW'(u) * PW'(LUT_X_SIZE - 1);
    end

    always_comb
    begin
        dq = div5(19'(s1_pos_reg[PW-1:12]));
        c0 = dq.quo[CW-1:0];
    end

    always_comb
    begin
        df = div5({s2_rem_reg, 4'b0000});
        cm = (s2_c0_reg == '0) ? s2_c0_reg : s2_c0_reg - CW'(1);
        c1 = (s2_c0_reg == CW'(LUT_X_SIZE - 1)) ? s2_c0_reg : s2_c0_reg + CW'(1);
        c2 = (c1 == CW'(LUT_X_SIZE - 1)) ? c1 : c1 + CW'(1);
        item_next.is_write = s2_wr_reg;
        item_next.waddr    = s2_waddr_reg;
        item_next.wdata    = s2_wdata_reg;
        item_next.col_m    = COL_MAX_W'(cm);
        item_next.col_0    = COL_MAX_W'(s2_c0_reg);
        item_next.col_1    = COL_MAX_W'(c1);
        item_next.col_2    = COL_MAX_W'(c2);
        item_next.frac     = df.quo[FRAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= item_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_wr_reg    <= (mode == MODE_WRITE);
            s1_waddr_reg <= table_address;
            s1_wdata_reg <= table_value;
            s1_pos_reg   <= pos;
            s2_wr_reg    <= s1_wr_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_wdata_reg <= s1_wdata_reg;
            s2_c0_reg    <= c0;
            s2_rem_reg   <= {dq.rem, s1_pos_reg[11:0]};
            s3_item_reg  <= item_next;
        end
    end

endmodule

// ===== src/tws_fifo.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper item queue
// Short queue that lets the front end and the back end stall on their own.
// ----------------------------------------------------------------------------
module tws_fifo import tws_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  tws_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output tws_item_t pop_item
);

    tws_item_t          entries_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg;
    logic [FIFO_PW-1:0] rd_ptr_reg;
    logic [FIFO_PW:0]   count_reg;
    logic               push;

    assign full      = (count_reg == (FIFO_PW + 1)'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entries_reg[rd_ptr_reg];
    assign push      = push_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (FIFO_PW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (FIFO_PW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/tws_back.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper back end
// Table storage, two Catmull-Rom row cubics, row blend and output register.
// ----------------------------------------------------------------------------
module tws_back import tws_pkg::*; #(
    parameter int unsigned LUT_X_SIZE = LUT_X_SIZE_DEF,
    parameter int unsigned LUT_D_SIZE = LUT_D_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [16:0]        distortion,
    input  logic               pop_valid,
    input  tws_item_t          pop_item,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [15:0] shaped_sample
);

    localparam int unsigned RW  = $clog2(LUT_D_SIZE);
    localparam int unsigned DPW = 16 + RW;

    logic [16:0]          d_cl;
    logic [RW-1:0]        row0;
    logic [RW-1:0]        row1;
    logic [DPW-1:0]       dpos_reg;
    logic [TABLE_AW-1:0]  base_reg [2];
    logic [FRAC_W-1:0]    fd_reg;

    logic                 adv;
    logic                 wr_en;
    logic [TABLE_AW-1:0]  addr [2][4];
    logic [COL_MAX_W-1:0] cols [4];
    logic [15:0]          rd_word [2][4];

    logic [9:1]           vld_reg;
    logic [FRAC_W-1:0]    s1_frac_reg;

    logic signed [19:0]   yv [2][4];
    logic signed [19:0]   b0_next [2];
    logic signed [19:0]   b1_next [2];
    logic signed [16:0]   b2_next [2];
    logic signed [16:0]   t1;

    logic signed [19:0]   s2_b0_reg [2];
    logic signed [19:0]   s2_b1_reg [2];
    logic signed [16:0]   s2_b2_reg [2];
    logic signed [15:0]   s2_y1_reg [2];
    logic signed [16:0]   s2_t_reg;

    logic signed [37:0]   s3_h1_reg [2];
    logic signed [16:0]   s3_b2_reg [2];
    logic signed [15:0]   s3_y1_reg [2];
    logic signed [16:0]   s3_t_reg;

    logic signed [19:0]   ha [2];
    logic signed [18:0]   la [2];
    logic signed [36:0]   s4_ph_reg [2];
    logic signed [36:0]   s4_pl_reg [2];
    logic signed [16:0]   s4_b2_reg [2];
    logic signed [15:0]   s4_y1_reg [2];
    logic signed [16:0]   s4_t_reg;

    logic signed [55:0]   h2 [2];
    logic signed [39:0]   s5_g_reg [2];
    logic signed [15:0]   s5_y1_reg [2];
    logic signed [16:0]   s5_t_reg;

    logic signed [21:0]   gh [2];
    logic signed [18:0]   gl [2];
    logic signed [38:0]   s6_ph_reg [2];
    logic signed [38:0]   s6_pl_reg [2];
    logic signed [15:0]   s6_y1_reg [2];

    logic signed [57:0]   h3 [2];
    logic signed [40:0]   s7_r_reg [2];

    logic signed [40:0]   s8_r0_reg;
    logic signed [41:0]   s8_diff_reg;

    logic signed [23:0]   dh;
    logic signed [18:0]   dl;
    logic signed [16:0]   fds;
    logic signed [40:0]   s9_r0_reg;
    logic signed [40:0]   s9_ph_reg;
    logic signed [40:0]   s9_pl_reg;

    logic signed [61:0]   blend;
    logic signed [29:0]   y_full;
    logic signed [15:0]   y_sat;
    logic                 result_valid_reg;
    logic signed [15:0]   shaped_sample_reg;

    // Row selection follows the distortion register.
    always_comb
    begin
        d_cl = (distortion > 17'd65536) ? 17'd65536 : distortion;
        row0 = dpos_reg[16 +: RW];
        row1 = (row0 == RW'(LUT_D_SIZE - 1)) ? row0 : row0 + RW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpos_reg    <= '0;
            base_reg[0] <= '0;
            base_reg[1] <= '0;
            fd_reg      <= '0;
        end
        else
        begin
            dpos_reg    <= DPW'(d_cl) * DPW'(LUT_D_SIZE - 1);
            base_reg[0] <= TABLE_AW'(32'(row0) * 32'(LUT_X_SIZE));
            base_reg[1] <= TABLE_AW'(32'(row1) * 32'(LUT_X_SIZE));
            fd_reg      <= dpos_reg[15:0];
        end
    end

    assign adv   = !result_valid_reg || result_ready;
    assign pop   = adv && pop_valid;
    assign wr_en = pop && pop_item.is_write;

    always_comb
    begin
        cols[0] = pop_item.col_m;
        cols[1] = pop_item.col_0;
        cols[2] = pop_item.col_1;
        cols[3] = pop_item.col_2;
        for (int r = 0; r < 2; r++)
            for (int k = 0; k < 4; k++)
                addr[r][k] = base_reg[r] + TABLE_AW'(cols[k]);
    end

    // Four table copies, one per tap; each copy reads both rows.
    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [15:0] mem [TABLE_DEPTH];
        logic [15:0] rd0_reg;
        logic [15:0] rd1_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
                mem[pop_item.waddr] <= pop_item.wdata;
            if (adv)
            begin
                rd0_reg <= mem[addr[0][k]];
                rd1_reg <= mem[addr[1][k]];
            end
        end

        assign rd_word[0][k] = rd0_reg;
        assign rd_word[1][k] = rd1_reg;
    end

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            for (int k = 0; k < 4; k++)
                yv[r][k] = 20'(signed'(rd_word[r][k]));
            b0_next[r] = -yv[r][0] + 20'sd3 * yv[r][1] - 20'sd3 * yv[r][2] + yv[r][3];
            b1_next[r] = 20'sd2 * yv[r][0] - 20'sd5 * yv[r][1] + 20'sd4 * yv[r][2]
                         - yv[r][3];
            b2_next[r] = 17'(yv[r][2] - yv[r][0]);
        end
        t1 = signed'({1'b0, s1_frac_reg});
    end

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            ha[r] = s3_h1_reg[r][37:18];
            la[r] = signed'({1'b0, s3_h1_reg[r][17:0]});
            h2[r] = (56'(s4_ph_reg[r]) <<< 18) + 56'(s4_pl_reg[r])
                    + (56'(s4_b2_reg[r]) <<< 32) + 56'sd32768;
            gh[r] = s5_g_reg[r][39:18];
            gl[r] = signed'({1'b0, s5_g_reg[r][17:0]});
            h3[r] = (58'(s6_ph_reg[r]) <<< 18) + 58'(s6_pl_reg[r])
                    + (58'(s6_y1_reg[r]) <<< 33) + 58'sd65536;
        end
        dh  = s8_diff_reg[41:18];
        dl  = signed'({1'b0, s8_diff_reg[17:0]});
        fds = signed'({1'b0, fd_reg});
        blend = (62'(s9_r0_reg) <<< 16) + (62'(s9_ph_reg) <<< 18) + 62'(s9_pl_reg)
                + 62'sd2147483648;
        y_full = blend[61:32];
        if (y_full > 30'sd32767)
            y_sat = 16'sh7FFF;
        else if (y_full < -30'sd32768)
            y_sat = 16'sh8000;
        else
            y_sat = 16'(y_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg          <= {vld_reg[8:1], pop_valid && !pop_item.is_write};
            result_valid_reg <= vld_reg[9];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_frac_reg <= pop_item.frac;
            for (int r = 0; r < 2; r++)
            begin
                s2_b0_reg[r] <= b0_next[r];
                s2_b1_reg[r] <= b1_next[r];
                s2_b2_reg[r] <= b2_next[r];
                s2_y1_reg[r] <= 16'(yv[r][1]);

                s3_h1_reg[r] <= 38'(s2_b0_reg[r]) * 38'(s2_t_reg)
                                + (38'(s2_b1_reg[r]) <<< 16);
                s3_b2_reg[r] <= s2_b2_reg[r];
                s3_y1_reg[r] <= s2_y1_reg[r];

                s4_ph_reg[r] <= 37'(ha[r]) * 37'(s3_t_reg);
                s4_pl_reg[r] <= 37'(la[r]) * 37'(s3_t_reg);
                s4_b2_reg[r] <= s3_b2_reg[r];
                s4_y1_reg[r] <= s3_y1_reg[r];

                s5_g_reg[r]  <= h2[r][55:16];
                s5_y1_reg[r] <= s4_y1_reg[r];

                s6_ph_reg[r] <= 39'(gh[r]) * 39'(s5_t_reg);
                s6_pl_reg[r] <= 39'(gl[r]) * 39'(s5_t_reg);
                s6_y1_reg[r] <= s5_y1_reg[r];

                s7_r_reg[r]  <= h3[r][57:17];
            end
            s2_t_reg <= t1;
            s3_t_reg <= s2_t_reg;
            s4_t_reg <= s3_t_reg;
            s5_t_reg <= s4_t_reg;

            s8_r0_reg   <= s7_r_reg[0];
            s8_diff_reg <= 42'(s7_r_reg[1]) - 42'(s7_r_reg[0]);

            s9_r0_reg <= s8_r0_reg;
            s9_ph_reg <= 41'(dh) * 41'(fds);
            s9_pl_reg <= 41'(dl) * 41'(fds);

            shaped_sample_reg <= y_sat;
        end
    end

    assign result_valid  = result_valid_reg;
    assign shaped_sample = shaped_sample_reg;

endmodule

// ===== src/table_waveshaper_cubic.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper with cubic interpolation
// Two-dimensional table waveshaper: Catmull-Rom along the sample axis and a
// linear blend between two rows chosen by the distortion register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, a table write or a sample, unless a
// full queue (backed up by a stalled result port) holds it back, and offers one
// result per sample: three front stages derive the column position, the
// four-entry queue passes it on, and the back end registers the table read and
// then passes through the two cubics, the blend and the output register. The
// rate is set by the table, which is held in four copies with two read ports
// each so that all eight taps are read together; a write updates all copies at
// once. The table is not cleared at reset and must be written before samples
// read it. Writes and samples are handled strictly in order, so a sample sees
// every earlier write.
module table_waveshaper_cubic import tws_pkg::*; #(
    parameter int unsigned LUT_X_SIZE = LUT_X_SIZE_DEF,
    parameter int unsigned LUT_D_SIZE = LUT_D_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [0:0]         mode,
    input  logic [12:0]        table_address,
    input  logic signed [15:0] table_value,
    input  logic signed [15:0] sample_in,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [15:0] shaped_sample
);

    logic [16:0] distortion_reg;
    logic [0:0]  reg_index;
    logic        queue_full;
    logic        push_valid;
    tws_item_t   push_item;
    logic        pop;
    logic        pop_valid;
    tws_item_t   pop_item;

    assign pready    = 1'b1;
    assign reg_index = paddr[2:2];
    assign prdata    = (reg_index == REG_DISTORTION) ? {15'b0, distortion_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            distortion_reg <= '0;
        else if (psel && penable && pwrite && (reg_index == REG_DISTORTION))
            distortion_reg <= pwdata[16:0];
    end

    tws_front #(
        .LUT_X_SIZE (LUT_X_SIZE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .mode          (mode),
        .table_address (table_address),
        .table_value   (table_value),
        .sample_in     (sample_in),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    tws_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    tws_back #(
        .LUT_X_SIZE (LUT_X_SIZE),
        .LUT_D_SIZE (LUT_D_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .distortion    (distortion_reg),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .shaped_sample (shaped_sample)
    );

endmodule

// ===== src/tws_checker.sv =====
// ----------------------------------------------------------------------------
// Table waveshaper port checker
// Checks result transfers and the register port as seen at the top level.
// ----------------------------------------------------------------------------
`include "table_waveshaper_cubic_defines.svh"

module tws_checker import tws_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [APB_AW-1:0]  paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [15:0] shaped_sample
);

    `TWS_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(shaped_sample), "stalled result changed")
    `TWS_ASSERT_ALWAYS(a_prdata_upper, prdata[31:17] == 15'd0, "register read has stray upper bits")
    `TWS_ASSERT(a_readback, (psel && penable && pwrite && pready && paddr[2] == REG_DISTORTION) ##1 (paddr[2] == REG_DISTORTION) |-> prdata[16:0] == $past(pwdata[16:0]), "distortion readback mismatch")

endmodule

bind table_waveshaper_cubic tws_checker u_checker (.*);
